@@ src/lfu_pkg.sv @@
// Shared constants for the least-frequently-used page replacement unit.
// No dependencies; used by lfu_page_replacement_unit.
package lfu_pkg;

	localparam int MAX_FRAMES_DEF = 16;
	localparam int PAGE_BITS_DEF  = 16;
	localparam int COUNT_BITS_DEF = 16;

	localparam int CFG_W         = 5;
	localparam int FRAMES_RESET  = 3;
	localparam int FRAME_IDX_W   = 4;
	localparam int TOTAL_W       = 32;

endpackage

@@ src/lfu_page_replacement_unit.sv @@
// Least-frequently-used page replacement table with saturating use counts.
// Depends on lfu_pkg for default sizes and result field widths.
//
// channel   dir  handshake                 beat contents
// s_        in   s_tvalid / s_tready       page_number
// m_        out  m_tvalid / m_tready       hit, frame_index, evicted_valid,
//                                          evicted_page, fault_total, hit_total
// cfg_      in   cfg_wr_en                 frames_in_use
//
// A reference steps through IDLE to accept, SCAN with one read of the page and
// count memories per active frame (nf, the active frame count) through one
// read port, DRAIN for the last read data, UPDATE for the read-modify-write.
// Reset clears the frame valid bits, fill pointer and totals; the memories
// are not cleared; invalid entries never hit or get reported as evicted.
// The result waits in an output register; a stalled m_tready holds the update
// cycle of the next reference until that register frees up.
module lfu_page_replacement_unit #(
	parameter int MAX_FRAMES = lfu_pkg::MAX_FRAMES_DEF,
	parameter int PAGE_BITS  = lfu_pkg::PAGE_BITS_DEF,
	parameter int COUNT_BITS = lfu_pkg::COUNT_BITS_DEF,
	localparam int S_W = ((PAGE_BITS + 7) / 8) * 8,
	localparam int OUT_FIELDS_W = 1 + lfu_pkg::FRAME_IDX_W + 1 + PAGE_BITS +
		2 * lfu_pkg::TOTAL_W,
	localparam int M_W = ((OUT_FIELDS_W + 7) / 8) * 8
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_wr_en,
	input  logic [lfu_pkg::CFG_W-1:0] cfg_wr_data,
	input  logic                     s_tvalid,
	output logic                     s_tready,
	input  logic [S_W-1:0]           s_tdata,   // page_number
	output logic                     m_tvalid,
	input  logic                     m_tready,
	// hit, frame_index, evicted_valid, evicted_page, fault_total, hit_total
	output logic [M_W-1:0]           m_tdata
);

	localparam int IDX_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
	localparam int NF_W  = $clog2(MAX_FRAMES + 1);
	localparam int TW    = lfu_pkg::TOTAL_W;
	localparam int FW    = lfu_pkg::FRAME_IDX_W;

	typedef enum logic [1:0] {
		IDLE,
		SCAN,
		DRAIN,
		UPDATE
	} state_t;

	state_t                  state_q;
	logic [lfu_pkg::CFG_W-1:0] frames_q;
	logic [PAGE_BITS-1:0]    page_q;
	logic [NF_W-1:0]         rd_cnt_q;
	logic [NF_W-1:0]         fill_q;
	logic [MAX_FRAMES-1:0]   occ_q;
	logic                    rd_vld_s1;
	logic [IDX_W-1:0]        idx_s1;
	logic [PAGE_BITS-1:0]    page_rd_s1;
	logic [COUNT_BITS-1:0]   cnt_rd_s1;
	logic                    found_q;
	logic [IDX_W-1:0]        hit_idx_q;
	logic [COUNT_BITS-1:0]   hit_cnt_q;
	logic [COUNT_BITS-1:0]   min_cnt_q;
	logic [IDX_W-1:0]        min_idx_q;
	logic [PAGE_BITS-1:0]    min_page_q;
	logic [TW-1:0]           faults_q;
	logic [TW-1:0]           hits_q;
	logic                    m_valid_q;
	logic [OUT_FIELDS_W-1:0] m_data_q;

	logic [PAGE_BITS-1:0]    page_mem [MAX_FRAMES];
	logic [COUNT_BITS-1:0]   cnt_mem [MAX_FRAMES];

	logic [NF_W-1:0]         nf;
	logic                    rd_en;
	logic                    go;
	logic                    fill_miss;
	logic [IDX_W-1:0]        slot;
	logic                    ev_valid;
	logic [PAGE_BITS-1:0]    ev_page;
	logic [COUNT_BITS-1:0]   new_cnt;
	logic [TW-1:0]           faults_nx;
	logic [TW-1:0]           hits_nx;
	logic                    match;

	// Clamp the frame count register into 1..MAX_FRAMES.
	always_comb begin
		if (frames_q == '0) begin
			nf = NF_W'(1);
		end else if (32'(frames_q) > 32'(MAX_FRAMES)) begin
			nf = NF_W'(MAX_FRAMES);
		end else begin
			nf = NF_W'(frames_q);
		end
	end

	assign rd_en     = (state_q == SCAN);
	assign go        = (state_q == UPDATE) && (!m_valid_q || m_tready);
	assign fill_miss = (fill_q < nf);
	assign match     = rd_vld_s1 && occ_q[idx_s1] && (page_rd_s1 == page_q);

	always_comb begin
		if (found_q) begin
			slot = hit_idx_q;
		end else if (fill_miss) begin
			slot = fill_q[IDX_W-1:0];
		end else begin
			slot = min_idx_q;
		end
		ev_valid = !found_q && !fill_miss && occ_q[min_idx_q];
		ev_page  = ev_valid ? min_page_q : '0;
		if (!found_q) begin
			new_cnt = COUNT_BITS'(1);
		end else if (hit_cnt_q == '1) begin
			new_cnt = hit_cnt_q;
		end else begin
			new_cnt = hit_cnt_q + COUNT_BITS'(1);
		end
		faults_nx = (!found_q && faults_q != '1) ? faults_q + TW'(1) : faults_q;
		hits_nx   = (found_q && hits_q != '1) ? hits_q + TW'(1) : hits_q;
	end

	// Page and count memories: one write port, one registered read port each.
	always_ff @(posedge clk) begin
		if (go && !found_q) begin
			page_mem[slot] <= page_q;
		end
		if (go) begin
			cnt_mem[slot] <= new_cnt;
		end
		if (rd_en) begin
			page_rd_s1 <= page_mem[rd_cnt_q[IDX_W-1:0]];
			cnt_rd_s1  <= cnt_mem[rd_cnt_q[IDX_W-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= IDLE;
			frames_q   <= lfu_pkg::CFG_W'(lfu_pkg::FRAMES_RESET);
			page_q     <= '0;
			rd_cnt_q   <= '0;
			fill_q     <= '0;
			occ_q      <= '0;
			rd_vld_s1  <= 1'b0;
			idx_s1     <= '0;
			found_q    <= 1'b0;
			hit_idx_q  <= '0;
			hit_cnt_q  <= '0;
			min_cnt_q  <= '0;
			min_idx_q  <= '0;
			min_page_q <= '0;
			faults_q   <= '0;
			hits_q     <= '0;
			m_valid_q  <= 1'b0;
			m_data_q   <= '0;
		end else begin
			if (cfg_wr_en) begin
				frames_q <= cfg_wr_data;
			end

			rd_vld_s1 <= rd_en;
			idx_s1    <= rd_cnt_q[IDX_W-1:0];

			// Keep the first match and the lowest count seen (first index wins ties).
			if (match && !found_q) begin
				found_q   <= 1'b1;
				hit_idx_q <= idx_s1;
				hit_cnt_q <= cnt_rd_s1;
			end
			if (rd_vld_s1 && (idx_s1 == '0 || cnt_rd_s1 < min_cnt_q)) begin
				min_cnt_q  <= cnt_rd_s1;
				min_idx_q  <= idx_s1;
				min_page_q <= page_rd_s1;
			end

			if (m_valid_q && m_tready && !go) begin
				m_valid_q <= 1'b0;
			end

			case (state_q)
				IDLE: begin
					if (s_tvalid) begin
						page_q   <= s_tdata[PAGE_BITS-1:0];
						rd_cnt_q <= '0;
						found_q  <= 1'b0;
						state_q  <= SCAN;
					end
				end
				SCAN: begin
					rd_cnt_q <= rd_cnt_q + NF_W'(1);
					if (rd_cnt_q == nf - NF_W'(1)) begin
						state_q <= DRAIN;
					end
				end
				DRAIN: begin
					state_q <= UPDATE;
				end
				UPDATE: begin
					if (go) begin
						if (!found_q) begin
							occ_q[slot] <= 1'b1;
							if (fill_miss) begin
								fill_q <= fill_q + NF_W'(1);
							end
						end
						faults_q  <= faults_nx;
						hits_q    <= hits_nx;
						m_valid_q <= 1'b1;
						m_data_q  <= {hits_nx, faults_nx, ev_page, ev_valid,
							FW'(slot), found_q};
						state_q   <= IDLE;
					end
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end

	assign s_tready = (state_q == IDLE);
	assign m_tvalid = m_valid_q;
	assign m_tdata  = M_W'(m_data_q);

endmodule
